>>> rtl/alu8f_pkg.sv
// Shared widths, operation codes and controller/datapath link types for the 8-bit ALU.
package alu8f_pkg;

  localparam int DATA_W = 8;
  localparam int OP_W   = 4;
  localparam int SH_W   = $clog2(DATA_W);

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [OP_W-1:0]   opcode_t;

  localparam opcode_t OP_ADD = 4'd0;
  localparam opcode_t OP_ADC = 4'd1;
  localparam opcode_t OP_SUB = 4'd2;
  localparam opcode_t OP_SBC = 4'd3;
  localparam opcode_t OP_MUL = 4'd4;
  localparam opcode_t OP_DIV = 4'd5;
  localparam opcode_t OP_RSB = 4'd6;
  localparam opcode_t OP_NEG = 4'd7;
  localparam opcode_t OP_AND = 4'd8;
  localparam opcode_t OP_OR  = 4'd9;
  localparam opcode_t OP_XOR = 4'd10;
  localparam opcode_t OP_NOT = 4'd11;
  localparam opcode_t OP_SHL = 4'd12;
  localparam opcode_t OP_ROR = 4'd13;
  localparam opcode_t OP_SHR = 4'd14;
  localparam opcode_t OP_ASR = 4'd15;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the incoming beat into the operand registers
    logic div_step;  // one restoring-division iteration
    logic commit;    // write result and flags into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_div; // the beat offered on the input channel is a divide
  } stat_t;

endpackage

>>> rtl/alu8f_if.sv
// Valid/ready channel interfaces for the ALU operand and result beats.
interface alu8f_in_if;
  import alu8f_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t operation;
  data_t   operand_a;
  data_t   operand_b;

  modport source (output valid, output operation, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input operation, input operand_a, input operand_b,
                  output ready);
endinterface

interface alu8f_out_if;
  import alu8f_pkg::*;

  logic  valid;
  logic  ready;
  data_t result;
  logic  zero;
  logic  carry;
  logic  negative;
  logic  overflow;

  modport source (output valid, output result, output zero, output carry,
                  output negative, output overflow, input ready);
  modport sink   (input valid, input result, input zero, input carry,
                  input negative, input overflow, output ready);
endinterface

>>> rtl/alu_8bit_with_flags.sv
// Top level of the 8-bit ALU with Z, C, N and V flags.
//
// Each input beat carries an operation code and two operand bytes and yields one
// result beat holding the result byte and the four flags. Carry and overflow are
// held in flag registers: operations that do not define them pass the stored
// values on, and add with carry and subtract with borrow read them. Every
// operation except divide is accepted and captured in the idle state and then
// goes through the shared adder, multiplier, shifter and logic unit in the
// execute state, which commits its result beat to the output register. Divide
// runs a restoring divider between those two states that produces one quotient
// bit per cycle; a zero divisor gives 255, and divide leaves the carry and
// overflow flags alone. The block works on one item at a time and is ready for
// a new operand beat as soon as the previous item has reached the output
// register, so a finished result may wait there for the sink while the next
// item is already being worked on; that next item then holds in its last cycle
// until the waiting beat is taken. Reset is synchronous and active low and
// clears both flags.
module alu_8bit_with_flags (
  input  logic         clk,
  input  logic         rst_n,
  alu8f_in_if.sink     in_beat,
  alu8f_out_if.source  out_beat
);
  import alu8f_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The controller owns all sequencing and the output valid flag.
  alu8f_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_beat.valid),
    .in_ready  (in_beat.ready),
    .out_valid (out_beat.valid),
    .out_ready (out_beat.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the operands, the divider, the flags and the result byte.
  alu8f_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_operation (in_beat.operation),
    .in_operand_a (in_beat.operand_a),
    .in_operand_b (in_beat.operand_b),
    .out_result   (out_beat.result),
    .out_zero     (out_beat.zero),
    .out_carry    (out_beat.carry),
    .out_negative (out_beat.negative),
    .out_overflow (out_beat.overflow)
  );

  // A commit must never overwrite a result beat that the sink has not taken.
  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_beat.valid || out_beat.ready))
    else $error("result register overwritten before it was taken");

  // A divide needs its iterations, so no commit can follow its acceptance directly.
  a_div_no_early_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat.valid && in_beat.ready && stat.in_is_div) |=> !cmd.commit)
    else $error("divide committed without iterating");

  // The flags change only when a result is committed.
  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !cmd.commit) |=> ($stable(out_beat.carry) && $stable(out_beat.overflow)))
    else $error("flags changed without a commit");

endmodule

>>> rtl/alu8f_ctrl.sv
// Controller state machine of the 8-bit ALU: sequences load, division steps and commit.
module alu8f_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  alu8f_pkg::stat_t stat,
  output alu8f_pkg::cmd_t  cmd
);
  import alu8f_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  localparam logic [SH_W-1:0] CNT_LAST = SH_W'(DATA_W - 1);

  logic [1:0]      state_r, state_nxt;
  logic [SH_W-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.in_is_div ? ST_DIV : ST_EXEC;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/alu8f_dp.sv
// Datapath of the 8-bit ALU: operand registers, shared adder, divider, flags and result register.
module alu8f_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  alu8f_pkg::cmd_t    cmd,
  output alu8f_pkg::stat_t   stat,
  input  alu8f_pkg::opcode_t in_operation,
  input  alu8f_pkg::data_t   in_operand_a,
  input  alu8f_pkg::data_t   in_operand_b,
  output alu8f_pkg::data_t   out_result,
  output logic               out_zero,
  output logic               out_carry,
  output logic               out_negative,
  output logic               out_overflow
);
  import alu8f_pkg::*;

  opcode_t op_r;
  data_t   a_r, b_r;
  data_t   rem_r, quot_r;
  data_t   result_r;
  logic    carry_flag_r, overflow_flag_r;

  data_t   res_nxt;
  logic    carry_nxt, overflow_nxt;

  data_t               add_x, add_y;
  logic                add_cin;
  logic [DATA_W:0]     add_sum;
  data_t               add_ovf_vec;
  logic [2*DATA_W-1:0] mul_w;
  logic [SH_W-1:0]     sh_amt;
  logic [2*DATA_W-1:0] shl_w;
  logic [2*DATA_W-1:0] ror_w;
  logic [DATA_W:0]     shr_w;
  logic signed [DATA_W:0] asr_w;
  logic [DATA_W:0]     div_trial, div_diff;
  logic                div_ge;

  assign stat.in_is_div = (in_operation == OP_DIV);

  // Shared adder: subtraction is x + ~y + carry-in, carry out means no borrow.
  always_comb begin
    add_x   = a_r;
    add_y   = b_r;
    add_cin = 1'b0;
    case (op_r)
      OP_ADC: add_cin = carry_flag_r;
      OP_SUB: begin
        add_y   = ~b_r;
        add_cin = 1'b1;
      end
      OP_SBC: begin
        add_y   = ~b_r;
        add_cin = carry_flag_r;
      end
      OP_RSB: begin
        add_x   = b_r;
        add_y   = ~a_r;
        add_cin = 1'b1;
      end
      default: add_cin = 1'b0;
    endcase
  end

  assign add_sum     = {1'b0, add_x} + {1'b0, add_y} + {{DATA_W{1'b0}}, add_cin};
  assign add_ovf_vec = ~(add_x ^ add_y) & (add_x ^ add_sum[DATA_W-1:0]);

  assign mul_w  = a_r * b_r;
  assign sh_amt = b_r[SH_W-1:0];
  assign shl_w  = {{DATA_W{1'b0}}, a_r} << sh_amt;
  assign ror_w  = {a_r, a_r} >> sh_amt;
  assign shr_w  = {a_r, 1'b0} >> sh_amt;
  assign asr_w  = $signed({a_r, 1'b0}) >>> sh_amt;

  always_comb begin
    res_nxt      = '0;
    carry_nxt    = carry_flag_r;
    overflow_nxt = overflow_flag_r;
    case (op_r)
      OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_RSB: begin
        res_nxt      = add_sum[DATA_W-1:0];
        carry_nxt    = add_sum[DATA_W];
        overflow_nxt = add_ovf_vec[DATA_W-1];
      end
      OP_MUL: res_nxt = mul_w[DATA_W-1:0];
      OP_DIV: res_nxt = quot_r;
      OP_NEG: res_nxt = data_t'(-b_r);
      OP_AND: res_nxt = a_r & b_r;
      OP_OR:  res_nxt = a_r | b_r;
      OP_XOR: res_nxt = a_r ^ b_r;
      OP_NOT: res_nxt = ~b_r;
      OP_SHL: begin
        res_nxt = shl_w[DATA_W-1:0];
        if (sh_amt != '0) carry_nxt = shl_w[DATA_W];
      end
      OP_ROR: begin
        res_nxt = ror_w[DATA_W-1:0];
        if (sh_amt != '0) carry_nxt = ror_w[DATA_W-1];
      end
      OP_SHR: begin
        res_nxt = shr_w[DATA_W:1];
        if (sh_amt != '0) carry_nxt = shr_w[0];
      end
      OP_ASR: begin
        res_nxt = asr_w[DATA_W:1];
        if (sh_amt != '0) carry_nxt = asr_w[0];
      end
      default: res_nxt = '0;
    endcase
  end

  // Restoring division, one quotient bit per step. A zero divisor yields all ones.
  assign div_trial = {rem_r, quot_r[DATA_W-1]};
  assign div_ge    = (div_trial >= {1'b0, b_r});
  assign div_diff  = div_trial - {1'b0, b_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      a_r    <= in_operand_a;
      b_r    <= in_operand_b;
      rem_r  <= '0;
      quot_r <= in_operand_a;
    end else if (cmd.div_step) begin
      rem_r  <= div_ge ? div_diff[DATA_W-1:0] : div_trial[DATA_W-1:0];
      quot_r <= {quot_r[DATA_W-2:0], div_ge};
    end
    if (cmd.commit) begin
      result_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_flag_r    <= 1'b0;
      overflow_flag_r <= 1'b0;
    end else if (cmd.commit) begin
      carry_flag_r    <= carry_nxt;
      overflow_flag_r <= overflow_nxt;
    end
  end

  assign out_result   = result_r;
  assign out_zero     = (result_r == '0);
  assign out_negative = result_r[DATA_W-1];
  assign out_carry    = carry_flag_r;
  assign out_overflow = overflow_flag_r;

endmodule
